// ----- design/orol_pkg.sv -----
// Package for the overwriting ring offset lookup: widths, opcodes, step codes
// and the microcode ROM that drives the sequencer.
// No dependencies; the interfaces and the lookup module import it.
package orol_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Field widths
    localparam int HANDLE_W   = 32;
    localparam int LEN_W      = 16;
    localparam int POS_W      = 20;
    localparam int SLOTF_W    = 4;
    localparam int REC_W      = HANDLE_W + LEN_W;

    // Opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // Sequencer step addresses
    typedef logic [2:0] t_step;
    localparam t_step ST_IDLE = 3'd0;
    localparam t_step ST_ADD  = 3'd1;
    localparam t_step ST_RD   = 3'd2;
    localparam t_step ST_CMP  = 3'd3;
    localparam t_step ST_MISS = 3'd4;
    localparam t_step ST_EMIT = 3'd5;

    // Branch conditions of a control word
    typedef enum logic [1:0] {
        COND_JUMP,      // always go to target
        COND_DISPATCH,  // wait for a request, branch on opcode and ring state
        COND_SCAN,      // hit -> target, last record -> miss, else stay
        COND_EMIT       // output free -> target, else stay
    } t_cond;

    // One control word
    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  take_req;  // request port ready
        logic  add_op;    // write record, move slots, build add result
        logic  rd_op;     // issue record read
        logic  scan_op;   // compare offset against record length
        logic  miss_op;   // build not-found result
        logic  emit_op;   // move result into the output register
    } t_ctl;

    // Microcode ROM
    function automatic t_ctl ucode(t_step pc);
        t_ctl ctl;
        ctl        = '0;
        ctl.cond   = COND_JUMP;
        ctl.target = ST_IDLE;
        case (pc)
            ST_IDLE: begin
                ctl.cond     = COND_DISPATCH;
                ctl.target   = ST_ADD;
                ctl.take_req = 1'b1;
            end
            ST_ADD: begin
                ctl.target = ST_EMIT;
                ctl.add_op = 1'b1;
            end
            ST_RD: begin
                ctl.target = ST_CMP;
                ctl.rd_op  = 1'b1;
            end
            ST_CMP: begin
                ctl.cond    = COND_SCAN;
                ctl.target  = ST_EMIT;
                ctl.rd_op   = 1'b1;
                ctl.scan_op = 1'b1;
            end
            ST_MISS: begin
                ctl.target  = ST_EMIT;
                ctl.miss_op = 1'b1;
            end
            ST_EMIT: begin
                ctl.cond    = COND_EMIT;
                ctl.target  = ST_IDLE;
                ctl.emit_op = 1'b1;
            end
            default: begin
                ctl.target = ST_IDLE;
            end
        endcase
        return ctl;
    endfunction

    // Ring slot increment with wrap
    function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // Slot number reported in the 4-bit slot field
    function automatic logic [SLOTF_W-1:0] slot_field(logic [SLOT_W-1:0] s);
        return SLOTF_W'(32'(s));
    endfunction

endpackage

// ----- design/orol_in_if.sv -----
// Request channel of the ring lookup: valid/ready plus the request fields.
// Depends on orol_pkg for the field widths.
interface orol_in_if import orol_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [HANDLE_W-1:0] record_handle;
    logic [LEN_W-1:0]    record_length;
    logic [POS_W-1:0]    byte_position;

    modport source (output valid, opcode, record_handle, record_length, byte_position,
                    input ready);
    modport sink   (input valid, opcode, record_handle, record_length, byte_position,
                    output ready);
endinterface

// ----- design/orol_out_if.sv -----
// Result channel of the ring lookup: valid/ready plus the result fields.
// Depends on orol_pkg for the field widths.
interface orol_out_if import orol_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [SLOTF_W-1:0]  slot;
    logic [HANDLE_W-1:0] found_handle;
    logic [LEN_W-1:0]    found_length;
    logic [LEN_W-1:0]    offset_in_record;
    logic                overwrote_oldest;

    modport source (output valid, hit, slot, found_handle, found_length,
                    offset_in_record, overwrote_oldest,
                    input ready);
    modport sink   (input valid, hit, slot, found_handle, found_length,
                    offset_in_record, overwrote_oldest,
                    output ready);
endinterface

// ----- design/orol_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module orol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/overwriting_ring_offset_lookup.sv -----
// Overwriting ring of write records with byte-offset lookup, microcoded.
// Add: an accepted request goes through the add step, then the emit step. Find: one stored
// record per cycle through the record RAM read port after a read step; a hit goes to emit,
// a miss after the last record or an empty ring goes through the miss step to emit.
// A new request is taken the cycle after the result enters the output register.
// Reset (synchronous, active low) empties the ring; record RAM is not cleared.
module overwriting_ring_offset_lookup import orol_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    orol_in_if.sink   i_req,
    orol_out_if.source o_rsp
);

    // Sequencer
    t_step r_pc, n_pc;
    t_ctl  ctl;

    // Ring pointers
    logic [SLOT_W-1:0] r_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_full;

    // Latched request and scan state
    logic [HANDLE_W-1:0] r_req_handle;
    logic [LEN_W-1:0]    r_req_len;
    logic [POS_W-1:0]    r_pos;
    logic [SLOT_W-1:0]   r_ptr;

    // Pending result
    logic                r_res_hit;
    logic [SLOTF_W-1:0]  r_res_slot;
    logic [HANDLE_W-1:0] r_res_handle;
    logic [LEN_W-1:0]    r_res_len;
    logic [LEN_W-1:0]    r_res_off;
    logic                r_res_ovw;

    // Output register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [SLOTF_W-1:0]  r_out_slot;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [LEN_W-1:0]    r_out_len;
    logic [LEN_W-1:0]    r_out_off;
    logic                r_out_ovw;

    logic              req_acc;
    logic              out_free;
    logic              ring_empty;
    logic              rec_hit;
    logic              rec_last;
    logic [SLOT_W-1:0] ptr_next;
    logic [SLOT_W-1:0] wr_next;
    logic [SLOT_W-1:0] rd_next;
    logic [SLOT_W-1:0] rd_addr;
    logic [REC_W-1:0]  rd_data;
    logic [HANDLE_W-1:0] rd_handle;
    logic [LEN_W-1:0]  rd_len;

    // Control word fetch and handshake terms
    assign ctl        = ucode(r_pc);
    assign req_acc    = i_req.valid && ctl.take_req;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign ring_empty = !r_full && (r_rd_slot == r_wr_slot);

    // Record RAM
    assign ptr_next  = next_slot(r_ptr);
    assign rd_addr   = ctl.scan_op ? ptr_next : r_ptr;
    assign rd_handle = rd_data[REC_W-1 -: HANDLE_W];
    assign rd_len    = rd_data[LEN_W-1:0];

    orol_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.add_op),
        .i_wr_addr (r_wr_slot),
        .i_wr_data ({r_req_handle, r_req_len}),
        .i_rd_en   (ctl.rd_op),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Scan compare
    assign rec_hit  = POS_W'(rd_len) > r_pos;
    assign rec_last = (ptr_next == r_wr_slot);

    // Add pointer moves
    assign wr_next = next_slot(r_wr_slot);
    assign rd_next = r_full ? next_slot(r_rd_slot) : r_rd_slot;

    // Next step
    always_comb begin
        n_pc = r_pc;
        case (ctl.cond)
            COND_JUMP: begin
                n_pc = ctl.target;
            end
            COND_DISPATCH: begin
                if (req_acc) begin
                    if (i_req.opcode == OP_ADD) begin
                        n_pc = ctl.target;
                    end else if (ring_empty) begin
                        n_pc = ST_MISS;
                    end else begin
                        n_pc = ST_RD;
                    end
                end
            end
            COND_SCAN: begin
                if (rec_hit) begin
                    n_pc = ctl.target;
                end else if (rec_last) begin
                    n_pc = ST_MISS;
                end
            end
            COND_EMIT: begin
                if (out_free) begin
                    n_pc = ctl.target;
                end
            end
            default: begin
                n_pc = ST_IDLE;
            end
        endcase
    end

    // Step counter and ring control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= ST_IDLE;
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_full    <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (ctl.add_op) begin
                r_wr_slot <= wr_next;
                r_rd_slot <= rd_next;
                r_full    <= (wr_next == rd_next);
            end
        end
    end

    // Request latch, scan state and pending result
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req_handle <= i_req.record_handle;
            r_req_len    <= i_req.record_length;
            r_pos        <= i_req.byte_position;
            r_ptr        <= r_rd_slot;
        end
        if (ctl.add_op) begin
            r_res_hit    <= 1'b0;
            r_res_slot   <= slot_field(r_wr_slot);
            r_res_handle <= '0;
            r_res_len    <= '0;
            r_res_off    <= '0;
            r_res_ovw    <= r_full;
        end
        if (ctl.scan_op) begin
            if (rec_hit) begin
                r_res_hit    <= 1'b1;
                r_res_slot   <= slot_field(r_ptr);
                r_res_handle <= rd_handle;
                r_res_len    <= rd_len;
                r_res_off    <= r_pos[LEN_W-1:0];
                r_res_ovw    <= 1'b0;
            end else begin
                r_pos <= r_pos - POS_W'(rd_len);
                r_ptr <= ptr_next;
            end
        end
        if (ctl.miss_op) begin
            r_res_hit    <= 1'b0;
            r_res_slot   <= '0;
            r_res_handle <= '0;
            r_res_len    <= '0;
            r_res_off    <= '0;
            r_res_ovw    <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit_op && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit_op && out_free) begin
            r_out_hit    <= r_res_hit;
            r_out_slot   <= r_res_slot;
            r_out_handle <= r_res_handle;
            r_out_len    <= r_res_len;
            r_out_off    <= r_res_off;
            r_out_ovw    <= r_res_ovw;
        end
    end

    // Port drive
    assign i_req.ready            = ctl.take_req;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.hit              = r_out_hit;
    assign o_rsp.slot             = r_out_slot;
    assign o_rsp.found_handle     = r_out_handle;
    assign o_rsp.found_length     = r_out_len;
    assign o_rsp.offset_in_record = r_out_off;
    assign o_rsp.overwrote_oldest = r_out_ovw;

    // Checks
    a_full_slots_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr_slot == r_rd_slot))
        else $error("ring full but write and read slots differ");

    a_add_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.opcode == OP_ADD) |=> (r_pc == ST_ADD))
        else $error("accepted add did not reach the add step");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit_op && out_free) |=> (r_out_valid && r_pc == ST_IDLE))
        else $error("result not presented after emit");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= ST_EMIT)
        else $error("step counter outside the microprogram");

endmodule
